/* hw/rtl/hnorm_pkg.sv */
// Shared constants for the heightmap normal generator.
// Holds register indexes, reset values and fixed-point constants.
// No dependencies.
package hnorm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_HORIZ_DIST   = 2'd3;

  // Register reset values.
  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd256;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd256;
  localparam logic [15:0] RST_MAX_HEIGHT   = 16'd256;
  localparam logic [15:0] RST_HORIZ_DIST   = 16'd256;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam logic [12:0] ROW_LIMIT = 13'd4096;
  localparam logic [12:0] MIN_SIZE  = 13'd2;

  // Division by 255: (x * ceil(2^32/255)) >> 32 is exact for x below 2^24.
  localparam logic [24:0] RECIP_255 = 25'd16843010;
  localparam logic [23:0] ROUND_255 = 24'd127;

  // Unit length in Q1.15, saturated.
  localparam logic [15:0] NORM_ONE = 16'h7FFF;

  // Slots of the scaled-height file.
  localparam logic [2:0] H_PIX   = 3'd0;
  localparam logic [2:0] H_UP    = 3'd1;
  localparam logic [2:0] H_CTR   = 3'd2;
  localparam logic [2:0] H_LEFT  = 3'd3;
  localparam logic [2:0] H_RIGHT = 3'd4;

endpackage

/* hw/rtl/heightmap_normal_generator.sv */
// Heightmap normal generator: line store, height scaling and normal unit.
// Depends on hnorm_pkg.
//
//  channel   | direction | words                     | handshake
//  s_axis    | in        | pixel                     | tvalid/tready
//  m_axis    | out       | vertex, tlast, tuser      | tvalid/tready
//  cfg       | in        | register index and data   | valid/ready (always ready)
//
// One pixel is taken at a time. A pixel of the first row gives no output word.
// A pixel that gives only border vertices skips the normal computation. A pixel
// with an interior vertex runs the bit-serial divider and square root once for
// each normal component; a zero-length normal skips them. The line store holds
// no reset state; state, counters and configuration registers clear at reset, the
// datapath registers do not.
// A stalled output word holds the block; no pixel is taken until it leaves.
module heightmap_normal_generator
  import hnorm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] col, [23:12] row, [39:24] height, [55:40] normal_x,
  // [71:56] normal_y, [87:72] normal_z
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o,   // [0] frame_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD0   = 4'd1;
  localparam logic [3:0] ST_RD1   = 4'd2;
  localparam logic [3:0] ST_SCALE = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_DINIT = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_OUT0  = 4'd8;
  localparam logic [3:0] ST_OUT1  = 4'd9;

  logic [3:0]  state_q;
  logic [4:0]  cnt_q;
  logic [1:0]  comp_q;

  logic [12:0] width_q, height_q;
  logic [15:0] max_h_q, hdist_q;

  logic [AW-1:0] col_q, c_q, ra_right_q;
  logic [11:0]   row_q, r_q;
  logic          emit_q, last_row_q, interior_q, fend_q;

  logic [7:0]  pix_q, older_q, prevc_q, left_q, right_q;
  logic [15:0] h_q [5];
  logic [23:0] prod1_q;
  logic [15:0] prod2_q;
  logic [31:0] sq_q [3];
  logic [2:0]  neg_q;
  logic [33:0] s_q;
  logic [34:0] rem_q;
  logic [30:0] quo_q;
  logic [15:0] root_q;
  logic [15:0] nrm_q [3];

  // Line store: high byte is two rows up, low byte one row up.
  logic [15:0]   line_mem [MAX_WIDTH];
  logic [15:0]   rd_data_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra;

  logic s_accept;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  // Effective sizes.
  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  always_comb begin
    if (width_q < MIN_SIZE) begin
      w_eff = WW'(2);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (height_q > ROW_LIMIT) begin
      h_eff = ROW_LIMIT;
    end else begin
      h_eff = height_q;
    end
  end

  // Position of the incoming pixel and the counters after it.
  logic          col_wrap;
  logic [AW-1:0] c_cur, col_nx;
  logic [12:0]   row_inc, r_cur13, r_plus;
  logic [11:0]   r_cur, row_nx;
  logic [WW-1:0] c_plus;
  always_comb begin
    col_wrap = WW'(col_q) >= w_eff;
    c_cur    = col_wrap ? '0 : col_q;
    row_inc  = {1'b0, row_q} + 13'(col_wrap);
    r_cur13  = (row_inc >= h_eff) ? 13'd0 : row_inc;
    r_cur    = r_cur13[11:0];
    c_plus   = WW'(c_cur) + WW'(1);
    r_plus   = {1'b0, r_cur} + 13'd1;
    if (c_plus >= w_eff) begin
      col_nx = '0;
      row_nx = (r_plus >= h_eff) ? 12'd0 : r_plus[11:0];
    end else begin
      col_nx = c_plus[AW-1:0];
      row_nx = r_cur;
    end
  end

  // Memory port control.
  always_comb begin
    mem_re = 1'b0;
    mem_we = (state_q == ST_RD0);
    mem_ra = c_cur;
    if (s_accept) begin
      mem_re = 1'b1;
    end else if (state_q == ST_RD0) begin
      mem_re = 1'b1;
      mem_ra = ra_right_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[c_q] <= {rd_data_q[7:0], pix_q};
    end
    if (mem_re) begin
      rd_data_q <= line_mem[mem_ra];
    end
  end

  // Scaling pipeline: height = (p * max_height + 127) / 255.
  logic [7:0]  scale_raw;
  logic [23:0] scale_sum;
  logic [48:0] scale_prod;
  always_comb begin
    case (cnt_q[2:0])
      H_PIX:   scale_raw = pix_q;
      H_UP:    scale_raw = older_q;
      H_CTR:   scale_raw = prevc_q;
      H_LEFT:  scale_raw = left_q;
      H_RIGHT: scale_raw = right_q;
      default: scale_raw = 8'd0;
    endcase
    scale_sum  = prod1_q + ROUND_255;
    scale_prod = 49'(scale_sum) * 49'(RECIP_255);
  end

  // Difference and square for one normal component.
  logic [15:0] sq_a, sq_b, sq_mag;
  logic [16:0] sq_diff;
  logic [31:0] sq_val;
  logic [33:0] sq_sum;
  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin
        sq_a = h_q[H_LEFT];
        sq_b = h_q[H_RIGHT];
      end
      2'd1: begin
        sq_a = hdist_q;
        sq_b = 16'd0;
      end
      default: begin
        sq_a = h_q[H_PIX];
        sq_b = h_q[H_UP];
      end
    endcase
    sq_diff = {1'b0, sq_a} - {1'b0, sq_b};
    sq_mag  = sq_diff[16] ? 16'(-sq_diff) : sq_diff[15:0];
    sq_val  = 32'(sq_mag) * 32'(sq_mag);
    sq_sum  = 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]);
  end

  // Restoring division step and square-root trial.
  logic        div_bit, div_ge;
  logic [34:0] div_trial;
  logic [15:0] sqrt_t, root_nx, comp_res;
  logic [31:0] sqrt_tt;
  always_comb begin
    div_bit   = (cnt_q == 5'd30) ? sq_q[comp_q][0] : 1'b0;
    div_trial = {rem_q[33:0], div_bit};
    div_ge    = div_trial >= {1'b0, s_q};
    sqrt_t    = root_q | (16'd1 << cnt_q[3:0]);
    sqrt_tt   = 32'(sqrt_t) * 32'(sqrt_t);
    root_nx   = (sqrt_tt <= {1'b0, quo_q}) ? sqrt_t : root_q;
    if (neg_q[comp_q]) begin
      comp_res = 16'(-root_nx);
    end else if (root_nx > NORM_ONE) begin
      comp_res = NORM_ONE;
    end else begin
      comp_res = root_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      comp_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      max_h_q  <= RST_MAX_HEIGHT;
      hdist_q  <= RST_HORIZ_DIST;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[12:0];
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
          CFG_MAX_HEIGHT:   max_h_q  <= cfg_data_i;
          CFG_HORIZ_DIST:   hdist_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            col_q   <= col_nx;
            row_q   <= row_nx;
            state_q <= ST_RD0;
          end
        end
        ST_RD0: begin
          state_q <= emit_q ? ST_RD1 : ST_IDLE;
        end
        ST_RD1: begin
          cnt_q   <= '0;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (cnt_q == 5'd6) begin
            cnt_q   <= '0;
            state_q <= interior_q ? ST_SQ : ST_OUT0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_SQ: begin
          if (cnt_q == 5'd3) begin
            comp_q  <= '0;
            state_q <= (sq_sum == 34'd0) ? ST_OUT0 : ST_DINIT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DINIT: begin
          cnt_q   <= 5'd30;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == 5'd0) begin
            cnt_q   <= 5'd15;
            state_q <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_SQRT: begin
          if (cnt_q == 5'd0) begin
            if (comp_q == 2'd2) begin
              state_q <= ST_OUT0;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= ST_DINIT;
            end
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        ST_OUT0: begin
          if (m_axis_tready_i) begin
            state_q <= last_row_q ? ST_OUT1 : ST_IDLE;
          end
        end
        ST_OUT1: begin
          if (m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pix_q      <= s_axis_tdata_i;
      c_q        <= c_cur;
      r_q        <= r_cur;
      emit_q     <= (r_cur != 12'd0);
      last_row_q <= ({1'b0, r_cur} == (h_eff - 13'd1));
      interior_q <= (r_cur >= 12'd2) && (c_cur != '0) && (c_plus < w_eff);
      fend_q     <= (c_plus == w_eff);
      ra_right_q <= (c_plus < w_eff) ? c_plus[AW-1:0] : c_cur;
    end
    if (state_q == ST_RD0) begin
      // The previous pixel's center sample is this pixel's left neighbor.
      left_q  <= prevc_q;
      prevc_q <= rd_data_q[7:0];
      older_q <= rd_data_q[15:8];
    end
    if (state_q == ST_RD1) begin
      right_q <= rd_data_q[7:0];
    end
    if (state_q == ST_SCALE) begin
      prod1_q <= 24'(scale_raw) * 24'(max_h_q);
      prod2_q <= scale_prod[47:32];
      if (cnt_q >= 5'd2) begin
        h_q[3'(cnt_q - 5'd2)] <= prod2_q;
      end
      if (cnt_q == 5'd6) begin
        nrm_q[0] <= 16'd0;
        nrm_q[1] <= NORM_ONE;
        nrm_q[2] <= 16'd0;
      end
    end
    if (state_q == ST_SQ) begin
      if (cnt_q == 5'd3) begin
        s_q <= sq_sum;
      end else begin
        sq_q[cnt_q[1:0]]  <= sq_val;
        neg_q[cnt_q[1:0]] <= sq_diff[16];
      end
    end
    if (state_q == ST_DINIT) begin
      rem_q <= 35'(sq_q[comp_q][31:1]);
      quo_q <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_q <= div_ge ? (div_trial - {1'b0, s_q}) : div_trial;
      quo_q <= {quo_q[29:0], div_ge};
      root_q <= '0;
    end
    if (state_q == ST_SQRT) begin
      root_q <= root_nx;
      if (cnt_q == 5'd0) begin
        nrm_q[comp_q] <= comp_res;
      end
    end
  end

  // Output word.
  logic [31:0] c_ext;
  always_comb begin
    c_ext           = 32'(c_q);
    m_axis_tvalid_o = (state_q == ST_OUT0) || (state_q == ST_OUT1);
    if (state_q == ST_OUT1) begin
      m_axis_tdata_o = {16'd0, NORM_ONE, 16'd0, h_q[H_PIX], r_q, c_ext[11:0]};
      m_axis_tlast_o = 1'b1;
      m_axis_tuser_o = fend_q;
    end else begin
      m_axis_tdata_o = {nrm_q[2], nrm_q[1], nrm_q[0], h_q[H_CTR], r_q - 12'd1,
                        c_ext[11:0]};
      m_axis_tlast_o = !last_row_q;
      m_axis_tuser_o = 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("pixel taken while word pending");
  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("frame end without tlast");
  a_read_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q == ST_RD0) else $error("line store read not issued");
`endif

endmodule
